>>> rtl/core/arm_dp_pkg.sv
// Shared types and constants for the ARM data-processing ALU pipeline.
// No dependencies; imported by every module of the block.
package arm_dp_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AmtW  = 8;
  localparam int unsigned Sh5W  = 5;

  // NZCV bit positions
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagV = 0;

  // r15 reads one word ahead when a register-specified shift is used
  localparam logic [DataW-1:0] PcOffset = 32'd4;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
    OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
    OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
    OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
  } alu_op_e;

  typedef enum logic [1:0] {
    SHK_LSL = 2'd0,
    SHK_LSR = 2'd1,
    SHK_ASR = 2'd2,
    SHK_ROR = 2'd3
  } shift_kind_e;

  // Operand-2 shifter behavior, resolved ahead of the barrel shifter
  typedef enum logic [2:0] {
    SM_PASS     = 3'd0,  // value as is, carry unchanged
    SM_PASS_C31 = 3'd1,  // value as is, carry = bit 31
    SM_NORM     = 3'd2,  // shift by 1..31
    SM_RRX      = 3'd3,  // rotate right through carry
    SM_ZERO_CB0 = 3'd4,  // zero, carry = bit 0
    SM_ZERO_C31 = 3'd5,  // zero, carry = bit 31
    SM_ZERO_CZ  = 3'd6,  // zero, carry = 0
    SM_FILL     = 3'd7   // sign fill, carry = bit 31
  } shift_mode_e;

  typedef struct packed {
    logic [3:0]       cmd;
    logic [DataW-1:0] first_operand;
    logic [DataW-1:0] second_operand;
    logic             use_immediate;
    logic             immediate_rotated;
    logic [1:0]       shift_kind;
    logic [AmtW-1:0]  shift_amount;
    logic             shift_by_register;
    logic             upd_flags;
    logic [3:0]       flags_in;
    logic             first_is_pc;
    logic             second_is_pc;
  } dp_in_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             write_result;
    logic [3:0]       flags_out;
  } dp_out_t;

  // operand stage -> shift stage
  typedef struct packed {
    logic [3:0]       cmd;
    logic [DataW-1:0] op1;
    logic [DataW-1:0] op2;
    shift_mode_e      mode;
    shift_kind_e      kind;
    logic [Sh5W-1:0]  amt;
    logic             upd_flags;
    logic [3:0]       flags_in;
  } opnd_t;

  // shift stage -> execute stage
  typedef struct packed {
    logic [3:0]       cmd;
    logic [DataW-1:0] op1;
    logic [DataW-1:0] op2;
    logic             sh_carry;
    logic             upd_flags;
    logic [3:0]       flags_in;
  } shft_t;

  // execute stage -> flag stage
  typedef struct packed {
    logic [DataW-1:0] res;
    logic             add_c;
    logic             add_v;
    logic             logical;
    logic             is_cmp;
    logic             sh_carry;
    logic             upd_flags;
    logic [3:0]       flags_in;
  } exec_t;

endpackage

>>> rtl/core/arm_dp_opnd.sv
// Stage 1: PC read adjust and operand-2 shift decode.
// Depends on arm_dp_pkg.
module arm_dp_opnd import arm_dp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  dp_in_t data_i,
  output logic   valid_o,
  output opnd_t  data_o
);

  logic  valid_q;
  opnd_t data_d, data_q;
  logic  amt_big;
  logic  amt_is32;

  always_comb begin
    data_d           = '0;
    data_d.cmd       = data_i.cmd;
    data_d.op1       = data_i.first_operand;
    data_d.op2       = data_i.second_operand;
    data_d.kind      = shift_kind_e'(data_i.shift_kind);
    data_d.amt       = data_i.shift_amount[Sh5W-1:0];
    data_d.upd_flags = data_i.upd_flags;
    data_d.flags_in  = data_i.flags_in;
    data_d.mode      = SM_NORM;
    amt_big          = |data_i.shift_amount[AmtW-1:Sh5W];
    amt_is32         = (data_i.shift_amount == AmtW'(DataW));

    if (!data_i.use_immediate && data_i.shift_by_register) begin
      if (data_i.first_is_pc)  data_d.op1 = data_i.first_operand + PcOffset;
      if (data_i.second_is_pc) data_d.op2 = data_i.second_operand + PcOffset;
    end

    priority if (data_i.use_immediate) begin
      data_d.mode = data_i.immediate_rotated ? SM_PASS_C31 : SM_PASS;
    end else if (!data_i.shift_by_register) begin
      if (data_d.amt == '0) begin
        unique case (data_d.kind)
          SHK_LSL: data_d.mode = SM_PASS;
          SHK_LSR: data_d.mode = SM_ZERO_C31;
          SHK_ASR: data_d.mode = SM_FILL;
          SHK_ROR: data_d.mode = SM_RRX;
          default: data_d.mode = SM_PASS;
        endcase
      end
    end else if (data_i.shift_amount == '0) begin
      data_d.mode = SM_PASS;
    end else if (amt_big || data_d.amt == '0) begin
      // amount of 32 or more
      unique case (data_d.kind)
        SHK_LSL: data_d.mode = amt_is32 ? SM_ZERO_CB0 : SM_ZERO_CZ;
        SHK_LSR: data_d.mode = amt_is32 ? SM_ZERO_C31 : SM_ZERO_CZ;
        SHK_ASR: data_d.mode = SM_FILL;
        SHK_ROR: data_d.mode = (data_d.amt == '0) ? SM_PASS_C31 : SM_NORM;
        default: data_d.mode = SM_PASS;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/arm_dp_shift.sv
// Stage 2: 32-bit barrel shifter with shifter carry-out.
// Depends on arm_dp_pkg.
module arm_dp_shift import arm_dp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  opnd_t data_i,
  output logic  valid_o,
  output shft_t data_o
);

  logic              valid_q;
  shft_t             data_d, data_q;
  logic [DataW:0]    lsl_w, lsr_w, asr_w;
  logic [2*DataW-1:0] ror_w;
  logic [DataW-1:0]  v;
  logic              cin;

  always_comb begin
    v     = data_i.op2;
    cin   = data_i.flags_in[FlagC];
    lsl_w = {1'b0, v} << data_i.amt;
    lsr_w = {v, 1'b0} >> data_i.amt;
    asr_w = $unsigned($signed({v, 1'b0}) >>> data_i.amt);
    ror_w = {v, v} >> data_i.amt;

    data_d           = '0;
    data_d.cmd       = data_i.cmd;
    data_d.op1       = data_i.op1;
    data_d.upd_flags = data_i.upd_flags;
    data_d.flags_in  = data_i.flags_in;
    data_d.op2       = v;
    data_d.sh_carry  = cin;

    unique case (data_i.mode)
      SM_PASS: ;
      SM_PASS_C31: data_d.sh_carry = v[DataW-1];
      SM_RRX: begin
        data_d.op2      = {cin, v[DataW-1:1]};
        data_d.sh_carry = v[0];
      end
      SM_ZERO_CB0: begin
        data_d.op2      = '0;
        data_d.sh_carry = v[0];
      end
      SM_ZERO_C31: begin
        data_d.op2      = '0;
        data_d.sh_carry = v[DataW-1];
      end
      SM_ZERO_CZ: begin
        data_d.op2      = '0;
        data_d.sh_carry = 1'b0;
      end
      SM_FILL: begin
        data_d.op2      = {DataW{v[DataW-1]}};
        data_d.sh_carry = v[DataW-1];
      end
      SM_NORM: begin
        unique case (data_i.kind)
          SHK_LSL: begin
            data_d.op2      = lsl_w[DataW-1:0];
            data_d.sh_carry = lsl_w[DataW];
          end
          SHK_LSR: begin
            data_d.op2      = lsr_w[DataW:1];
            data_d.sh_carry = lsr_w[0];
          end
          SHK_ASR: begin
            data_d.op2      = asr_w[DataW:1];
            data_d.sh_carry = asr_w[0];
          end
          SHK_ROR: begin
            data_d.op2      = ror_w[DataW-1:0];
            data_d.sh_carry = ror_w[DataW-1];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/arm_dp_exec.sv
// Stage 3: logic unit and 32-bit adder for the 16 data-processing opcodes.
// Depends on arm_dp_pkg.
module arm_dp_exec import arm_dp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  shft_t data_i,
  output logic  valid_o,
  output exec_t data_o
);

  logic             valid_q;
  exec_t            data_d, data_q;
  logic [DataW-1:0] a, b;
  logic             ci;
  logic [DataW:0]   sum;
  logic             cf;

  always_comb begin
    cf = data_i.flags_in[FlagC];
    a  = data_i.op1;
    b  = ~data_i.op2;
    ci = 1'b1;
    unique case (alu_op_e'(data_i.cmd))
      OP_RSB: begin a = data_i.op2; b = ~data_i.op1; ci = 1'b1; end
      OP_ADD, OP_CMN: begin b = data_i.op2; ci = 1'b0; end
      OP_ADC: begin b = data_i.op2; ci = cf; end
      OP_SBC: ci = cf;
      OP_RSC: begin a = data_i.op2; b = ~data_i.op1; ci = cf; end
      default: ;
    endcase
    sum = {1'b0, a} + {1'b0, b} + {{DataW{1'b0}}, ci};

    data_d           = '0;
    data_d.add_c     = sum[DataW];
    data_d.add_v     = (a[DataW-1] ^ sum[DataW-1]) & (b[DataW-1] ^ sum[DataW-1]);
    data_d.sh_carry  = data_i.sh_carry;
    data_d.upd_flags = data_i.upd_flags;
    data_d.flags_in  = data_i.flags_in;
    data_d.is_cmp    = (data_i.cmd[3:2] == 2'b10);
    data_d.logical   = 1'b1;
    data_d.res       = sum[DataW-1:0];

    unique case (alu_op_e'(data_i.cmd))
      OP_AND, OP_TST: data_d.res = data_i.op1 & data_i.op2;
      OP_EOR, OP_TEQ: data_d.res = data_i.op1 ^ data_i.op2;
      OP_ORR:         data_d.res = data_i.op1 | data_i.op2;
      OP_MOV:         data_d.res = data_i.op2;
      OP_BIC:         data_d.res = data_i.op1 & ~data_i.op2;
      OP_MVN:         data_d.res = ~data_i.op2;
      default:        data_d.logical = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/arm_dp_flags.sv
// Stage 4: NZCV update and output register.
// Depends on arm_dp_pkg.
module arm_dp_flags import arm_dp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  exec_t   data_i,
  output logic    valid_o,
  output dp_out_t data_o
);

  logic    valid_q;
  dp_out_t data_d, data_q;
  logic    upd;

  always_comb begin
    upd                  = data_i.upd_flags | data_i.is_cmp;
    data_d.result        = data_i.is_cmp ? '0 : data_i.res;
    data_d.write_result  = ~data_i.is_cmp;
    data_d.flags_out     = data_i.flags_in;
    if (upd) begin
      data_d.flags_out[FlagN] = data_i.res[DataW-1];
      data_d.flags_out[FlagZ] = (data_i.res == '0);
      if (data_i.logical) begin
        data_d.flags_out[FlagC] = data_i.sh_carry;
      end else begin
        data_d.flags_out[FlagC] = data_i.add_c;
        data_d.flags_out[FlagV] = data_i.add_v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/arm_data_processing_alu.sv
// ARMv4 data-processing ALU with barrel shifter, top level.
// Depends on arm_dp_pkg and the four arm_dp_* stage modules.
//
// One data-processing instruction (AND..MVN) per beat. The block accepts a
// new beat every clock cycle while in_stall_o is low. Stages in order:
// stage 1 adds the r15 read offset and resolves the shifter mode, stage 2
// runs the barrel shifter, stage 3 the logic unit and the 32-bit adder,
// stage 4 updates NZCV into the output register. Each stage holds its own
// valid bit; a stage moves whenever it is empty or the stage after it moves,
// so bubbles collapse under output stall and nothing is dropped or repeated.
// in_stall_o rises only when all four stages hold a beat and out_stall_i is
// high. Unstalled, throughput is one beat per cycle (single-pass pipeline).
module arm_data_processing_alu import arm_dp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_out_t out_data_o
);

  logic  v1, v2, v3, v4;
  logic  en1, en2, en3, en4;
  opnd_t s1;
  shft_t s2;
  exec_t s3;

  // stage advance chain, output side first
  assign en4 = ~v4 | ~out_stall_i;
  assign en3 = ~v3 | en4;
  assign en2 = ~v2 | en3;
  assign en1 = ~v1 | en2;

  assign in_stall_o  = ~en1;
  assign out_valid_o = v4;

  arm_dp_opnd u_opnd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (v1),
    .data_o  (s1)
  );

  arm_dp_shift u_shift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .data_i  (s1),
    .valid_o (v2),
    .data_o  (s2)
  );

  arm_dp_exec u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en3),
    .valid_i (v2),
    .data_i  (s2),
    .valid_o (v3),
    .data_o  (s3)
  );

  arm_dp_flags u_flags (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en4),
    .valid_i (v3),
    .data_i  (s3),
    .valid_o (v4),
    .data_o  (out_data_o)
  );

endmodule

>>> rtl/core/arm_dp_alu_chk.sv
// Port-level checker for arm_data_processing_alu, bound to the top level.
// Depends on arm_dp_pkg.
module arm_dp_alu_chk import arm_dp_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_stall_o,
  input logic    out_valid_o,
  input logic    out_stall_i,
  input dp_out_t out_data_o
);

  // held output beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed under stall");

  // backpressure only comes from a stalled full output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

  // an accepted beat reaches the output while the output side keeps moving
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted beat did not arrive in four cycles");

  // compare opcodes report a zero result
  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_result |-> out_data_o.result == '0)
    else $error("compare result not zero");

endmodule

bind arm_data_processing_alu arm_dp_alu_chk u_arm_dp_alu_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
